### hdl/dss_pkg.sv
package dss_pkg;

    localparam int CMD_W     = 3;
    localparam int TRACK_W   = 4;
    localparam int FPB_W     = 17;
    localparam int BEAT_W    = 4;
    localparam int MASK_W    = 9;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam logic [FPB_W-1:0] FPB_RESET = 17'd48000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK        = 3'd0,
        CMD_HIT         = 3'd1,
        CMD_CLEAR_TRACK = 3'd2,
        CMD_CLEAR_ALL   = 3'd3,
        CMD_START       = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        REG_FPB        = 2'd0,
        REG_START_BEAT = 2'd1,
        REG_METRO_ONLY = 2'd2,
        REG_METRO_ON   = 2'd3
    } t_reg;

    typedef struct packed {
        logic merge;
        logic clear_all;
        logic clear_track;
        logic set_pending;
    } t_pat_op;

endpackage

### hdl/drum_step_sequencer_top.sv
// Channel    Dir  Payload (low bit first)                                     Beat
// s_axis     in   tdata: command[2:0], track[6:3], zero pad                    one command
// m_axis     out  tdata: trigger_mask[8:0], hit_beat[12:9], beat_position[16:13],
//                 loop_wrapped[17], zero pad                                  one result
// apb        in   beat length 0x0, start_beat 0x4, metronome_only 0x8,
//                 metronome_on 0xC                                             one register
// Every accepted beat yields one result beat; one beat per cycle is sustained while m_axis_tready is high.
// Each beat passes the input register, then the decode logic, then the result register.
// Reset clears both maps, the position, the valid flags and APB registers but beat length (48000).
// A stalled output holds its beat while one more input beat waits in the input register.
module drum_step_sequencer_top #(
    parameter int TRACKS = 9,
    parameter int BEATS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [dss_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // command, track
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [(TRACKS+2*$clog2(BEATS)+8)/8*8-1:0] m_axis_tdata, // mask, hit, position, wrapped
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dss_pkg::APB_AW-1:0]         paddr,
    input  logic [dss_pkg::APB_DW-1:0]         pwdata,
    output logic [dss_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    localparam int BW    = $clog2(BEATS);
    localparam int RES_W = TRACKS + 2 * BW + 1;
    localparam int OUT_W = (RES_W + 7) / 8 * 8;
    localparam logic [TRACKS-1:0] METRO_BIT = TRACKS'(1) << (TRACKS - 1);

    logic [dss_pkg::FPB_W-1:0]   r_fpb;
    logic [dss_pkg::BEAT_W-1:0]  r_start_beat;
    logic                        r_metro_only;
    logic                        r_metro_on;
    dss_pkg::t_reg               reg_idx;

    logic                        r_in_valid;
    dss_pkg::t_cmd               r_cmd;
    logic [dss_pkg::TRACK_W-1:0] r_track;
    logic                        r_out_valid;
    logic [TRACKS-1:0]           r_mask;
    logic [BW-1:0]               r_hit;
    logic [BW-1:0]               r_pos;
    logic                        r_wrapped;

    logic                        advance;
    logic                        track_ok;
    logic [BW-1:0]               cur_beat;
    logic                        trig_ok;
    logic [BW-1:0]               hit_beat;
    logic                        wrap;
    logic [BW-1:0]               pos;
    logic [TRACKS-1:0]           row;
    dss_pkg::t_pat_op            pat_op;
    logic [TRACKS-1:0]           n_mask;
    logic [BW-1:0]               n_hit;

    assign pready  = 1'b1;
    assign reg_idx = dss_pkg::t_reg'(paddr[3:2]);

    always_comb begin
        case (reg_idx)
            dss_pkg::REG_FPB:        prdata = 32'(r_fpb);
            dss_pkg::REG_START_BEAT: prdata = 32'(r_start_beat);
            dss_pkg::REG_METRO_ONLY: prdata = 32'(r_metro_only);
            dss_pkg::REG_METRO_ON:   prdata = 32'(r_metro_on);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpb        <= dss_pkg::FPB_RESET;
            r_start_beat <= '0;
            r_metro_only <= 1'b0;
            r_metro_on   <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                dss_pkg::REG_FPB:        r_fpb        <= pwdata[dss_pkg::FPB_W-1:0];
                dss_pkg::REG_START_BEAT: r_start_beat <= pwdata[dss_pkg::BEAT_W-1:0];
                dss_pkg::REG_METRO_ONLY: r_metro_only <= pwdata[0];
                dss_pkg::REG_METRO_ON:   r_metro_on   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd   <= dss_pkg::t_cmd'(s_axis_tdata[2:0]);
            r_track <= s_axis_tdata[6:3];
        end
    end

    dss_position #(
        .BEATS(BEATS)
    ) u_position (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_cmd        (r_cmd),
        .i_fpb        (r_fpb),
        .i_start_beat (r_start_beat),
        .o_beat       (cur_beat),
        .o_trig_ok    (trig_ok),
        .o_hit_beat   (hit_beat),
        .o_wrap       (wrap),
        .o_pos        (pos)
    );

    assign track_ok = int'(r_track) < TRACKS;

    always_comb begin
        pat_op = '0;
        n_mask = '0;
        n_hit  = '0;
        case (r_cmd)
            dss_pkg::CMD_TICK: begin
                pat_op.merge = wrap;
                if (trig_ok) begin
                    if (!r_metro_only) begin
                        n_mask = row & ~METRO_BIT;
                    end
                    if (r_metro_on) begin
                        n_mask = n_mask | METRO_BIT;
                    end
                end
            end
            dss_pkg::CMD_HIT: begin
                n_hit              = hit_beat;
                pat_op.set_pending = track_ok;
                if (track_ok) begin
                    n_mask = TRACKS'(1) << r_track;
                end
            end
            dss_pkg::CMD_CLEAR_TRACK: pat_op.clear_track = track_ok;
            dss_pkg::CMD_CLEAR_ALL:   pat_op.clear_all   = 1'b1;
            dss_pkg::CMD_START:       pat_op.merge       = 1'b1;
            default: begin
            end
        endcase
    end

    dss_pattern #(
        .TRACKS(TRACKS),
        .BEATS (BEATS)
    ) u_pattern (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_op       (pat_op),
        .i_track    (r_track),
        .i_hit_beat (hit_beat),
        .i_rd_beat  (cur_beat),
        .o_row      (row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_mask    <= n_mask;
            r_hit     <= n_hit;
            r_pos     <= pos;
            r_wrapped <= wrap && (r_cmd == dss_pkg::CMD_TICK);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_wrapped, r_pos, r_hit, r_mask});

    a_wrap_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_wrapped |-> (r_pos == BW'(BEATS - 1)))
        else $error("loop wrap reported away from the last beat");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_cmd) && $stable(r_track))
        else $error("waiting command lost");

endmodule

### hdl/dss_position.sv
module dss_position #(
    parameter int BEATS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  dss_pkg::t_cmd                        i_cmd,
    input  logic [dss_pkg::FPB_W-1:0]            i_fpb,
    input  logic [dss_pkg::BEAT_W-1:0]           i_start_beat,
    output logic [$clog2(BEATS)-1:0]             o_beat,
    output logic                                 o_trig_ok,
    output logic [$clog2(BEATS)-1:0]             o_hit_beat,
    output logic                                 o_wrap,
    output logic [$clog2(BEATS)-1:0]             o_pos
);

    localparam int BW = $clog2(BEATS);
    localparam logic [BW-1:0] LAST_BEAT = BW'(BEATS - 1);

    logic [dss_pkg::FPB_W-1:0] r_phase, n_phase;
    logic [BW-1:0]             r_beat, n_beat;
    logic [BW-1:0]             r_gate, n_gate;

    logic                      end_beat;
    logic                      last_beat;
    logic                      late;
    logic [BW-1:0]             beat_inc;
    logic [BW-1:0]             start_sel;

    always_comb begin
        end_beat  = ({1'b0, r_phase} + 18'd1) >= {1'b0, i_fpb};
        late      = {r_phase, 1'b0} >= {1'b0, i_fpb};
        last_beat = (r_beat == LAST_BEAT);
        beat_inc  = last_beat ? '0 : r_beat + BW'(1);
        start_sel = (int'(i_start_beat) < BEATS) ? BW'(i_start_beat) : '0;
    end

    always_comb begin
        n_phase = r_phase;
        n_beat  = r_beat;
        n_gate  = r_gate;
        o_wrap  = 1'b0;
        o_pos   = r_beat;
        case (i_cmd)
            dss_pkg::CMD_TICK: begin
                if (end_beat) begin
                    n_phase = '0;
                    n_beat  = beat_inc;
                    if (last_beat) begin
                        n_gate = '0;
                        o_wrap = 1'b1;
                    end
                end else begin
                    n_phase = r_phase + 17'd1;
                end
            end
            dss_pkg::CMD_START: begin
                n_phase = '0;
                n_beat  = start_sel;
                n_gate  = start_sel;
                o_pos   = start_sel;
            end
            default: begin
            end
        endcase
    end

    assign o_beat     = r_beat;
    assign o_trig_ok  = (r_phase == '0) && (r_beat >= r_gate);
    assign o_hit_beat = late ? beat_inc : r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_beat  <= '0;
            r_gate  <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_beat  <= n_beat;
            r_gate  <= n_gate;
        end
    end

    a_beat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_beat) < BEATS)
        else $error("beat counter out of range");

    a_wrap_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_wrap |=> (r_gate == '0) && (r_beat == '0) && (r_phase == '0))
        else $error("loop wrap did not reset position and gate");

    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (i_cmd == dss_pkg::CMD_START) |=> (r_phase == '0) && (r_gate == r_beat))
        else $error("start did not align gate and beat");

endmodule

### hdl/dss_pattern.sv
module dss_pattern #(
    parameter int TRACKS = 9,
    parameter int BEATS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  dss_pkg::t_pat_op                  i_op,
    input  logic [dss_pkg::TRACK_W-1:0]       i_track,
    input  logic [$clog2(BEATS)-1:0]          i_hit_beat,
    input  logic [$clog2(BEATS)-1:0]          i_rd_beat,
    output logic [TRACKS-1:0]                 o_row
);

    logic [BEATS-1:0] r_beat_map [TRACKS];
    logic [BEATS-1:0] n_beat_map [TRACKS];
    logic [BEATS-1:0] r_pend_map [TRACKS];
    logic [BEATS-1:0] n_pend_map [TRACKS];

    always_comb begin
        for (int t = 0; t < TRACKS; t++) begin
            n_beat_map[t] = r_beat_map[t];
            n_pend_map[t] = r_pend_map[t];
            if (i_op.merge) begin
                n_beat_map[t] = r_beat_map[t] | r_pend_map[t];
                n_pend_map[t] = '0;
            end
            if (i_op.clear_all) begin
                n_beat_map[t] = '0;
            end
            if (i_op.clear_track && (int'(i_track) == t)) begin
                n_beat_map[t] = '0;
            end
            if (i_op.set_pending && (int'(i_track) == t)) begin
                n_pend_map[t][i_hit_beat] = 1'b1;
            end
            o_row[t] = r_beat_map[t][i_rd_beat];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TRACKS; t++) begin
                r_beat_map[t] <= '0;
                r_pend_map[t] <= '0;
            end
        end else if (i_en) begin
            for (int t = 0; t < TRACKS; t++) begin
                r_beat_map[t] <= n_beat_map[t];
                r_pend_map[t] <= n_pend_map[t];
            end
        end
    end

    a_merge_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_op.merge |=> (r_pend_map[0] == '0) && (r_pend_map[TRACKS-1] == '0))
        else $error("pending map not cleared by merge");

endmodule

### dv/drum_step_sequencer_checker.sv
`timescale 1ns / 100ps

module drum_step_sequencer_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [dss_pkg::IN_DATA_W-1:0]  i_s_tdata,   // command[2:0], track[6:3], zero pad
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [dss_pkg::OUT_DATA_W-1:0] i_m_tdata,   // mask, hit, position, wrapped, pad
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [dss_pkg::APB_AW-1:0]     i_paddr,
    input  logic [dss_pkg::APB_DW-1:0]     i_pwdata,
    input  logic                           i_pready,
    output int                             o_errors,
    output int                             o_outstanding,
    output int                             o_results,
    output int                             o_wraps,
    output int                             o_hits
);

    localparam int TRACKS = 9;
    localparam int BEATS  = 16;
    localparam logic [dss_pkg::MASK_W-1:0] METRO_BIT = dss_pkg::MASK_W'(1) << (TRACKS - 1);

    typedef struct packed {
        logic                       wrapped;
        logic [dss_pkg::BEAT_W-1:0] pos;
        logic [dss_pkg::BEAT_W-1:0] hit;
        logic [dss_pkg::MASK_W-1:0] mask;
    } t_seq_result;

    localparam int RES_W = $bits(t_seq_result);

    logic [dss_pkg::MASK_W-1:0] grid        [BEATS];
    logic [dss_pkg::MASK_W-1:0] queued_hits [BEATS];
    logic [dss_pkg::BEAT_W-1:0] beat_no;
    logic [dss_pkg::FPB_W-1:0]  phase;
    logic [dss_pkg::BEAT_W-1:0] gate_beat;
    logic [dss_pkg::FPB_W-1:0]  cfg_fpb;
    logic [dss_pkg::BEAT_W-1:0] cfg_start;
    logic                       cfg_metro_only;
    logic                       cfg_metro_on;

    t_seq_result owed_results [$];
    t_seq_result want;
    t_seq_result got;
    int          error_count;
    int          result_count;
    int          wrap_count;
    int          hit_count;

    task automatic fold_hits();
        for (int b = 0; b < BEATS; b++) begin
            grid[b]        = grid[b] | queued_hits[b];
            queued_hits[b] = '0;
        end
    endtask

    task automatic predict_beat(input logic [dss_pkg::CMD_W-1:0] cmd,
                                input logic [dss_pkg::TRACK_W-1:0] trk);
        t_seq_result             r;
        logic [dss_pkg::FPB_W:0] next_phase;
        r     = '0;
        r.pos = beat_no;
        case (cmd)
            dss_pkg::CMD_TICK: begin
                if (phase == '0 && beat_no >= gate_beat) begin
                    if (!cfg_metro_only) r.mask = grid[beat_no] & ~METRO_BIT;
                    if (cfg_metro_on) r.mask = r.mask | METRO_BIT;
                end
                next_phase = {1'b0, phase} + 1'b1;
                if (next_phase >= {1'b0, cfg_fpb}) begin
                    phase = '0;
                    if (beat_no == BEATS - 1) begin
                        beat_no   = '0;
                        gate_beat = '0;
                        fold_hits();
                        r.wrapped = 1'b1;
                        wrap_count++;
                    end else begin
                        beat_no = beat_no + 1'b1;
                    end
                end else begin
                    phase = next_phase[dss_pkg::FPB_W-1:0];
                end
            end
            dss_pkg::CMD_HIT: begin
                r.hit = ({phase, 1'b0} >= {1'b0, cfg_fpb}) ?
                        dss_pkg::BEAT_W'(beat_no + 1'b1) : beat_no;
                if (trk < TRACKS) begin
                    r.mask             = dss_pkg::MASK_W'(1) << trk;
                    queued_hits[r.hit] = queued_hits[r.hit] | r.mask;
                end
                hit_count++;
            end
            dss_pkg::CMD_CLEAR_TRACK: begin
                if (trk < TRACKS) begin
                    for (int b = 0; b < BEATS; b++) grid[b][trk] = 1'b0;
                end
            end
            dss_pkg::CMD_CLEAR_ALL: begin
                for (int b = 0; b < BEATS; b++) grid[b] = '0;
            end
            dss_pkg::CMD_START: begin
                fold_hits();
                beat_no   = cfg_start;
                gate_beat = cfg_start;
                phase     = '0;
                r.pos     = beat_no;
            end
            default: begin
            end
        endcase
        owed_results.insert(owed_results.size(), r);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BEATS; b++) begin
                grid[b]        = '0;
                queued_hits[b] = '0;
            end
            beat_no        = '0;
            phase          = '0;
            gate_beat      = '0;
            cfg_fpb        = dss_pkg::FPB_RESET;
            cfg_start      = '0;
            cfg_metro_only = 1'b0;
            cfg_metro_on   = 1'b0;
            owed_results.delete();
            error_count    = 0;
            result_count   = 0;
            wrap_count     = 0;
            hit_count      = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    dss_pkg::REG_FPB:        cfg_fpb        = i_pwdata[dss_pkg::FPB_W-1:0];
                    dss_pkg::REG_START_BEAT: cfg_start      = i_pwdata[dss_pkg::BEAT_W-1:0];
                    dss_pkg::REG_METRO_ONLY: cfg_metro_only = i_pwdata[0];
                    dss_pkg::REG_METRO_ON:   cfg_metro_on   = i_pwdata[0];
                    default: begin
                    end
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[RES_W-1:0];
                if (owed_results.size() == 0) begin
                    $display("%0t: result beat with nothing predicted, actual tdata %h",
                             $time, i_m_tdata);
                    error_count++;
                end else begin
                    want = owed_results.pop_front();
                    result_count++;
                    if (got.mask !== want.mask || got.hit !== want.hit || got.pos !== want.pos
                        || got.wrapped !== want.wrapped
                        || i_m_tdata[dss_pkg::OUT_DATA_W-1:RES_W] !== '0) begin
                        $display("%0t: mismatch expected mask %h hit %0d pos %0d wrap %0d",
                                 $time, want.mask, want.hit, want.pos, want.wrapped);
                        $display("%0t:          actual   mask %h hit %0d pos %0d wrap %0d pad %h",
                                 $time, got.mask, got.hit, got.pos, got.wrapped,
                                 i_m_tdata[dss_pkg::OUT_DATA_W-1:RES_W]);
                        error_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_beat(i_s_tdata[dss_pkg::CMD_W-1:0],
                             i_s_tdata[dss_pkg::CMD_W+dss_pkg::TRACK_W-1:dss_pkg::CMD_W]);
            end
        end
        o_errors      <= error_count;
        o_outstanding <= owed_results.size();
        o_results     <= result_count;
        o_wraps       <= wrap_count;
        o_hits        <= hit_count;
    end

endmodule

### dv/tb_drum_step_sequencer_top.sv
`timescale 1ns / 100ps

module tb_drum_step_sequencer_top;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [dss_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // command[2:0], track[6:3], zero pad
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [dss_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // mask, hit, position, wrapped, pad
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [dss_pkg::APB_AW-1:0]     paddr;
    logic [dss_pkg::APB_DW-1:0]     pwdata;
    logic [dss_pkg::APB_DW-1:0]     prdata;
    logic                           pready;

    int errors;
    int outstanding;
    int results;
    int wraps;
    int hits;
    int n_settings;
    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold_req;

    always #5 i_clk = ~i_clk;

    drum_step_sequencer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    drum_step_sequencer_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_results     (results),
        .o_wraps       (wraps),
        .o_hits        (hits)
    );

    function automatic int idle_len();
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_beat(input logic [dss_pkg::CMD_W-1:0] cmd,
                             input logic [dss_pkg::TRACK_W-1:0] trk);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, trk, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random();
        int                          roll;
        logic [dss_pkg::CMD_W-1:0]   cmd;
        logic [dss_pkg::TRACK_W-1:0] trk;
        roll = $urandom_range(0, 99);
        trk  = ($urandom_range(0, 7) == 0) ? dss_pkg::TRACK_W'($urandom_range(9, 15))
                                           : dss_pkg::TRACK_W'($urandom_range(0, 8));
        if (roll < 60)      cmd = dss_pkg::CMD_TICK;
        else if (roll < 82) cmd = dss_pkg::CMD_HIT;
        else if (roll < 88) cmd = dss_pkg::CMD_CLEAR_TRACK;
        else if (roll < 90) cmd = dss_pkg::CMD_CLEAR_ALL;
        else if (roll < 96) cmd = dss_pkg::CMD_START;
        else                cmd = dss_pkg::CMD_W'($urandom_range(5, 7));
        send_beat(cmd, trk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input dss_pkg::t_reg idx, input logic [dss_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [dss_pkg::FPB_W-1:0] fpb,
                              input logic [dss_pkg::BEAT_W-1:0] start,
                              input logic only, input logic metro);
        apb_write(dss_pkg::REG_FPB, dss_pkg::APB_DW'(fpb));
        apb_write(dss_pkg::REG_START_BEAT, dss_pkg::APB_DW'(start));
        apb_write(dss_pkg::REG_METRO_ONLY, dss_pkg::APB_DW'(only));
        apb_write(dss_pkg::REG_METRO_ON, dss_pkg::APB_DW'(metro));
        n_settings++;
    endtask

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [dss_pkg::FPB_W-1:0] fpb;
        int                        roll;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        rx_hold_req   = 1'b0;
        n_settings    = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, an out-of-range hit and an unknown command.
        send_beat(dss_pkg::CMD_TICK, 4'd0);
        send_beat(dss_pkg::CMD_HIT, 4'd0);
        send_beat(dss_pkg::CMD_HIT, 4'd15);
        send_beat(3'd5, 4'd15);
        drain();

        // Zero frames per beat acts as one; metronome track, clears and unknown codes.
        set_config('0, '0, 1'b0, 1'b1);
        send_beat(dss_pkg::CMD_HIT, 4'd8);
        send_beat(dss_pkg::CMD_START, 4'd0);
        send_beat(dss_pkg::CMD_TICK, 4'd0);
        send_beat(dss_pkg::CMD_TICK, 4'd15);
        send_beat(dss_pkg::CMD_TICK, 4'd0);
        send_beat(3'd7, 4'd0);
        send_beat(dss_pkg::CMD_CLEAR_TRACK, 4'd0);
        send_beat(dss_pkg::CMD_CLEAR_TRACK, 4'd15);
        send_beat(dss_pkg::CMD_CLEAR_ALL, 4'd0);
        send_beat(dss_pkg::CMD_HIT, 4'd3);
        drain();

        // Longest beat, last start beat, then the beat shortened below the phase.
        set_config(17'h1FFFF, 4'd15, 1'b1, 1'b0);
        send_beat(dss_pkg::CMD_START, 4'd0);
        send_beat(dss_pkg::CMD_TICK, 4'd0);
        send_beat(dss_pkg::CMD_TICK, 4'd0);
        send_beat(dss_pkg::CMD_HIT, 4'd2);
        drain();
        apb_write(dss_pkg::REG_FPB, dss_pkg::APB_DW'(1));
        send_beat(dss_pkg::CMD_TICK, 4'd0);
        drain();
        apb_write(dss_pkg::REG_METRO_ONLY, dss_pkg::APB_DW'(0));
        apb_write(dss_pkg::REG_METRO_ON, dss_pkg::APB_DW'(1));
        n_settings++;
        send_beat(dss_pkg::CMD_START, 4'd0);
        send_beat(dss_pkg::CMD_TICK, 4'd0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            roll = $urandom_range(0, 19);
            if (roll == 0)     fpb = '0;
            else if (roll == 1) fpb = 17'h1FFFF;
            else if (roll < 5) fpb = dss_pkg::FPB_W'($urandom_range(5, 40));
            else               fpb = dss_pkg::FPB_W'($urandom_range(1, 4));
            if (ph == 0)       set_config(17'd1, 4'd15, 1'b1, 1'b1);
            else if (ph == 1)  set_config(17'd2, 4'd0, 1'b0, 1'b0);
            else               set_config(fpb, dss_pkg::BEAT_W'($urandom_range(0, 15)),
                                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            tx_idle_on = (ph == 2) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
            rx_idle_on = (ph == 2) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
            if (ph == 4) rx_hold_req = 1'b1;
            send_beat(dss_pkg::CMD_START, dss_pkg::TRACK_W'($urandom_range(0, 15)));
            repeat (139) send_random();
            drain();
        end

        $display("Covered %0d result beats across %0d register settings.", results, n_settings);
        $display("Loop wraps predicted: %0d, hit commands: %0d.", wraps, hits);
        if (errors == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
hdl/dss_pkg.sv
hdl/dss_position.sv
hdl/dss_pattern.sv
hdl/drum_step_sequencer_top.sv
dv/drum_step_sequencer_checker.sv
dv/tb_drum_step_sequencer_top.sv
